// ===== hdl/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared constants, types and the quarter-wave sine table of the tone
// generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

   localparam int PHASE_BITS      = 24;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int COUNT_BITS      = 22;

   localparam int QTR_BITS  = TABLE_ADDR_BITS - 2;
   localparam int QTR_SIZE  = 1 << QTR_BITS;

   localparam int WAVE_BITS     = 31;  // Q30 value in [0, 2^30]
   localparam int VOLUME_BITS   = 16;
   localparam int IDLE_BITS     = 22;
   localparam int LEVEL_BITS    = 16;
   localparam int STEP_BITS     = 24;
   localparam int DURATION_BITS = 22;
   localparam int CSR_DATA_BITS = 22;
   localparam int FRAC_BITS     = 30;

   localparam logic [VOLUME_BITS-1:0] VOLUME_RESET = 16'd65535;
   localparam logic [IDLE_BITS-1:0]   IDLE_RESET   = 22'd220500;

   localparam logic [WAVE_BITS:0] WAVE_ONE = 32'h4000_0000;

   localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SERIES_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_BEEP = 1'b1
   } op_type;

   typedef enum logic {
      CSR_VOLUME     = 1'b0,
      CSR_IDLE_LIMIT = 1'b1
   } csr_index_type;

   // Tick word handed from the control stage to the wave stage
   typedef struct packed {
      logic [TABLE_ADDR_BITS-1:0] addr;
      logic                       sounding;
      logic                       output_on;
   } tick_type;

   typedef logic [QTR_SIZE:0][WAVE_BITS-1:0] qtab_type;

   // sin over one quarter wave, Q30, Taylor series to x^13 with truncation.
   // Evaluated at elaboration only.
   function automatic qtab_type build_qtab();
      qtab_type    tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] s;
      for (int r = 0; r <= QTR_SIZE; r++) begin
         x  = (64'(r) * HALF_PI_Q30) >> QTR_BITS;
         x2 = (x * x) >> FRAC_BITS;
         t  = Q30_ONE;
         for (int i = 0; i < 6; i++) begin
            d = ((x2 * t) >> FRAC_BITS) / SERIES_DIV[i];
            t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
         end
         s = (x * t) >> FRAC_BITS;
         if (s > Q30_ONE) begin
            s = Q30_ONE;
         end
         tab[r] = s[WAVE_BITS-1:0];
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

endpackage

// ===== hdl/tsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsg_ctrl
// Tone state: phase accumulator, tone and silence counters, output enable.
// Registers one tick word per accepted tick.
// ----------------------------------------------------------------------------
module tsg_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [tsg_pkg::STEP_BITS-1:0]        req_phase_step,
   input  logic [tsg_pkg::DURATION_BITS-1:0]    req_duration_ticks,
   input  logic [tsg_pkg::IDLE_BITS-1:0]        idle_limit,
   input  logic                                 take,
   output logic                                 tick_valid,
   output tsg_pkg::tick_type                    tick
);

   localparam logic [tsg_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [tsg_pkg::PHASE_BITS-1:0] phase_acc_ff,     phase_acc_in;
   logic [tsg_pkg::PHASE_BITS-1:0] tone_step_ff,     tone_step_in;
   logic [tsg_pkg::COUNT_BITS-1:0] ticks_left_ff,    ticks_left_in;
   logic [tsg_pkg::COUNT_BITS-1:0] silence_ff,       silence_in;
   logic                           enabled_ff,       enabled_in;
   logic                           tick_valid_ff,    tick_valid_in;
   tsg_pkg::tick_type              tick_ff,          tick_in;

   logic accept;
   logic is_beep;
   logic room;

   assign room      = !tick_valid_ff || take;
   assign req_stall = !room;
   assign accept    = req_valid && room;
   assign is_beep   = (tsg_pkg::op_type'(req_operation) == tsg_pkg::OP_BEEP);

   always_comb begin
      phase_acc_in  = phase_acc_ff;
      tone_step_in  = tone_step_ff;
      ticks_left_in = ticks_left_ff;
      silence_in    = silence_ff;
      enabled_in    = enabled_ff;
      tick_in       = tick_ff;
      tick_valid_in = tick_valid_ff && !take;
      if (accept && is_beep) begin
         tone_step_in  = req_phase_step[tsg_pkg::PHASE_BITS-1:0];
         ticks_left_in = req_duration_ticks[tsg_pkg::COUNT_BITS-1:0];
         silence_in    = '0;
         enabled_in    = 1'b1;
      end else if (accept) begin
         tick_in.addr     = phase_acc_ff[tsg_pkg::PHASE_BITS-1 -: tsg_pkg::TABLE_ADDR_BITS];
         tick_in.sounding = 1'b0;
         if (enabled_ff) begin
            if (ticks_left_ff != '0) begin
               tick_in.sounding = 1'b1;
               ticks_left_in    = ticks_left_ff - tsg_pkg::COUNT_BITS'(1);
            end else begin
               if (silence_ff > idle_limit) begin
                  enabled_in = 1'b0;
               end
               if (silence_ff != COUNT_MAX) begin
                  silence_in = silence_ff + tsg_pkg::COUNT_BITS'(1);
               end
            end
         end
         tick_in.output_on = enabled_in;
         phase_acc_in      = phase_acc_ff + tone_step_ff;
         tick_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff  <= '0;
         tone_step_ff  <= '0;
         ticks_left_ff <= '0;
         silence_ff    <= '0;
         enabled_ff    <= 1'b0;
         tick_valid_ff <= 1'b0;
      end else begin
         phase_acc_ff  <= phase_acc_in;
         tone_step_ff  <= tone_step_in;
         ticks_left_ff <= ticks_left_in;
         silence_ff    <= silence_in;
         enabled_ff    <= enabled_in;
         tick_valid_ff <= tick_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
   end

   assign tick_valid = tick_valid_ff;
   assign tick       = tick_ff;

endmodule

// ===== hdl/tsg_wave.sv =====
// ----------------------------------------------------------------------------
// tsg_wave
// Quarter-wave table fold, volume scaling and the result register.
// ----------------------------------------------------------------------------
module tsg_wave (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tick_valid,
   input  tsg_pkg::tick_type                    tick,
   input  logic [tsg_pkg::VOLUME_BITS-1:0]      volume,
   output logic                                 take,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tsg_pkg::LEVEL_BITS-1:0]       rsp_level,
   output logic                                 rsp_sounding,
   output logic                                 rsp_output_on
);

   localparam int PROD_BITS = tsg_pkg::WAVE_BITS + tsg_pkg::VOLUME_BITS;

   logic [1:0]                          quad;
   logic [tsg_pkg::QTR_BITS-1:0]        offset;
   logic [tsg_pkg::QTR_BITS:0]          qidx;
   logic [tsg_pkg::WAVE_BITS-1:0]       qval;
   logic [tsg_pkg::WAVE_BITS:0]         wsum;
   logic [tsg_pkg::WAVE_BITS-1:0]       wave;
   logic [PROD_BITS-1:0]                prod;
   logic [tsg_pkg::LEVEL_BITS-1:0]      level;

   logic                                rsp_valid_ff,     rsp_valid_in;
   logic [tsg_pkg::LEVEL_BITS-1:0]      level_ff;
   logic                                sounding_ff;
   logic                                output_on_ff;

   assign quad   = tick.addr[tsg_pkg::TABLE_ADDR_BITS-1 -: 2];
   assign offset = tick.addr[tsg_pkg::QTR_BITS-1:0];

   // odd quadrants run the quarter table backwards
   assign qidx = quad[0] ? ((tsg_pkg::QTR_BITS+1)'(tsg_pkg::QTR_SIZE) - {1'b0, offset})
                         : {1'b0, offset};
   assign qval = tsg_pkg::QTAB[qidx];
   assign wsum = quad[1] ? (tsg_pkg::WAVE_ONE - {1'b0, qval})
                         : (tsg_pkg::WAVE_ONE + {1'b0, qval});
   assign wave = wsum[tsg_pkg::WAVE_BITS:1];

   // wave <= 2^30, so the product never reaches bit 46
   assign prod  = PROD_BITS'(wave) * PROD_BITS'(volume);
   assign level = tick.sounding ? prod[tsg_pkg::FRAC_BITS +: tsg_pkg::LEVEL_BITS] : '0;

   assign take         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = take ? tick_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && tick_valid) begin
         level_ff     <= level;
         sounding_ff  <= tick.sounding;
         output_on_ff <= tick.output_on;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = level_ff;
   assign rsp_sounding  = sounding_ff;
   assign rsp_output_on = output_on_ff;

endmodule

// ===== hdl/timed_sine_tone_generator.sv =====
// ----------------------------------------------------------------------------
// timed_sine_tone_generator
// Sample-tick driven sine beep source with volume and idle power-down.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one word per event. operation = beep loads phase_step and
//    duration_ticks and turns the output on; it returns no word.
//    operation = tick returns exactly one rsp word: level, sounding, output_on.
//  - csr port: write-only, index 0 = volume, index 1 = idle_limit. Write only
//    while no tick is in flight.
//  - An accepted tick is registered in the control stage, then in the result
//    stage, whose register drives rsp.
//  - Throughput: one word per cycle while rsp_stall is low, set by the two
//    register stages (tone control stage, then table/multiply result stage).
//  - Reset (synchronous): counters, phase and enable clear, volume = full
//    scale, idle_limit = 220500 ticks; rsp_valid drops at once.
//  - rsp_stall holds the result word; one more tick is held in the control
//    stage, and req_stall rises only when both stages are full.
//  - Phase keeps running across beeps; it is not restarted by a beep.
// ----------------------------------------------------------------------------
module timed_sine_tone_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [tsg_pkg::STEP_BITS-1:0]        req_phase_step,
   input  logic [tsg_pkg::DURATION_BITS-1:0]    req_duration_ticks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tsg_pkg::LEVEL_BITS-1:0]       rsp_level,
   output logic                                 rsp_sounding,
   output logic                                 rsp_output_on,
   input  logic                                 csr_write,
   input  logic                                 csr_index,
   input  logic [tsg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // csr registers
   logic [tsg_pkg::VOLUME_BITS-1:0] volume_ff,     volume_in;
   logic [tsg_pkg::IDLE_BITS-1:0]   idle_limit_ff, idle_limit_in;

   // stage link
   logic              take;
   logic              tick_valid;
   tsg_pkg::tick_type tick;

   always_comb begin
      volume_in     = volume_ff;
      idle_limit_in = idle_limit_ff;
      if (csr_write) begin
         case (tsg_pkg::csr_index_type'(csr_index))
            tsg_pkg::CSR_VOLUME:     volume_in     = csr_wdata[tsg_pkg::VOLUME_BITS-1:0];
            tsg_pkg::CSR_IDLE_LIMIT: idle_limit_in = csr_wdata[tsg_pkg::IDLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff     <= tsg_pkg::VOLUME_RESET;
         idle_limit_ff <= tsg_pkg::IDLE_RESET;
      end else begin
         volume_ff     <= volume_in;
         idle_limit_ff <= idle_limit_in;
      end
   end

   // tone control: counters, phase, enable
   tsg_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_phase_step     (req_phase_step),
      .req_duration_ticks (req_duration_ticks),
      .idle_limit         (idle_limit_ff),
      .take               (take),
      .tick_valid         (tick_valid),
      .tick               (tick)
   );

   // sine lookup, volume scaling, result register
   tsg_wave u_wave (
      .clock         (clock),
      .reset         (reset),
      .tick_valid    (tick_valid),
      .tick          (tick),
      .volume        (volume_ff),
      .take          (take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_sounding  (rsp_sounding),
      .rsp_output_on (rsp_output_on)
   );

endmodule

// ===== hdl/tsg_checker.sv =====
// ----------------------------------------------------------------------------
// tsg_checker
// Port-level checks of the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module tsg_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_stall,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [tsg_pkg::LEVEL_BITS-1:0]       rsp_level,
   input  logic                                 rsp_sounding,
   input  logic                                 rsp_output_on
);

   // a nonzero level only comes from a playing tone
   a_level_needs_tone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_level != '0) |-> rsp_sounding)
      else $error("nonzero level while not sounding");

   // a playing tone means the output is enabled
   a_tone_needs_enable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sounding) |-> rsp_output_on)
      else $error("sounding while output is off");

   // no result word directly after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

   // a stalled result word holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_level) && $stable(rsp_sounding) && $stable(rsp_output_on)))
      else $error("stalled result word changed");

   // input backs up only behind a stalled result word
   a_stall_from_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without result back-pressure");

endmodule

bind timed_sine_tone_generator tsg_checker u_tsg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_level          (rsp_level),
   .rsp_sounding       (rsp_sounding),
   .rsp_output_on      (rsp_output_on)
);

// ===== tb/sv/tb_timed_sine_tone_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_sine_tone_generator
// Self-checking bench for the sample-tick sine beep source. A short table of
// hand-picked words runs first, then phases of random beep/tick sequences
// under different volume and idle-limit settings. Every tick word is checked
// against a typed result or a bit-exact model of the phase, sine table and timers.
// ----------------------------------------------------------------------------
module tb_timed_sine_tone_generator;
   import tsg_pkg::*;

   localparam logic [63:0] UNITY      = 64'h4000_0000;   // 1.0 in Q30
   localparam logic [63:0] HALF_PI    = 64'd1686629713;  // pi/2 in Q30
   localparam int          FRAC       = 30;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;    // silence counter saturates here
   localparam int          PRESSURE_HOLD = 48;          // long receiver hold-off, cycles
   localparam int          SETTLE_CYCLES = 4;           // two-stage pipe plus margin
   localparam int          PHASE_COUNT   = 6;
   localparam int          PHASE_WORDS   = 95;

   // one result word
   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  sounding;
      logic                  output_on;
   } sample_type;

   // one row of the directed table; typed = result written out by hand
   typedef struct packed {
      op_type                   op;
      logic [STEP_BITS-1:0]     step;
      logic [DURATION_BITS-1:0] dur;
      logic                     typed;
      logic [LEVEL_BITS-1:0]    want_level;
      logic                     want_sounding;
      logic                     want_on;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 20;

   // Phase is 0 at the first beep because every tick before it steps by 0.
   // Later rows walk the phase to exact quarter points: zero crossing, peak,
   // zero crossing, trough.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd0,     1'b0, 1'b0}, // off after reset
      '{OP_TICK, 24'hFFFFFF, 22'h3FFFFF, 1'b1, 16'd0,     1'b0, 1'b0}, // tick ignores fields
      '{OP_BEEP, 24'h000000, 22'h000000, 1'b0, 16'd0,     1'b0, 1'b0}, // zero duration
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd0,     1'b0, 1'b1}, // on but silent
      '{OP_BEEP, 24'h000000, 22'h000002, 1'b0, 16'd0,     1'b0, 1'b0},
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd32767, 1'b1, 1'b1}, // mid scale at phase 0
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd32767, 1'b1, 1'b1},
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd0,     1'b0, 1'b1}, // tone over
      '{OP_BEEP, 24'hFFFFFF, 22'h3FFFFF, 1'b0, 16'd0,     1'b0, 1'b0}, // max step and length
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd32767, 1'b1, 1'b1},
      '{OP_TICK, 24'h000000, 22'h000000, 1'b0, 16'd0,     1'b0, 1'b0}, // phase wraps
      '{OP_TICK, 24'h000000, 22'h000000, 1'b0, 16'd0,     1'b0, 1'b0},
      '{OP_BEEP, 24'h000003, 22'h000001, 1'b0, 16'd0,     1'b0, 1'b0}, // beep keeps phase
      '{OP_TICK, 24'h000000, 22'h000000, 1'b0, 16'd0,     1'b0, 1'b0}, // phase back to 0
      '{OP_BEEP, 24'h400000, 22'h000004, 1'b0, 16'd0,     1'b0, 1'b0}, // quarter turn/tick
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd32767, 1'b1, 1'b1},
      '{OP_TICK, 24'h000000, 22'h000000, 1'b0, 16'd0,     1'b0, 1'b0}, // peak
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd32767, 1'b1, 1'b1},
      '{OP_TICK, 24'h000000, 22'h000000, 1'b0, 16'd0,     1'b0, 1'b0}, // trough
      '{OP_TICK, 24'h000000, 22'h000000, 1'b1, 16'd0,     1'b0, 1'b1}
   };

   // DUT signals; the inputs are known from time 0
   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   logic                     req_operation      = 1'b0;
   logic [STEP_BITS-1:0]     req_phase_step     = '0;
   logic [DURATION_BITS-1:0] req_duration_ticks = '0;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   logic [LEVEL_BITS-1:0]    rsp_level;
   logic                     rsp_sounding;
   logic                     rsp_output_on;
   logic                     csr_write          = 1'b0;
   logic                     csr_index          = 1'b0;
   logic [CSR_DATA_BITS-1:0] csr_wdata          = '0;

   // tone model state
   logic [PHASE_BITS-1:0]    phase_acc;
   logic [PHASE_BITS-1:0]    tone_step;
   logic [COUNT_BITS-1:0]    ticks_left;
   logic [COUNT_BITS-1:0]    silence_count;
   logic                     tone_on;
   logic [VOLUME_BITS-1:0]   gain;
   logic [IDLE_BITS-1:0]     idle_ticks;
   logic [63:0]              qsine [0:QTR_SIZE];

   sample_type expected_samples [$];
   int      mismatches      = 0;
   bit      no_idle         = 1'b0;   // last phase: neither side idles
   bit      pressure_go     = 1'b0;
   int      pressure_cycles = 0;      // owned by the receiver process
   int      sender_calm     = 0;

   timed_sine_tone_generator uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_phase_step     (req_phase_step),
      .req_duration_ticks (req_duration_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_level          (rsp_level),
      .rsp_sounding       (rsp_sounding),
      .rsp_output_on      (rsp_output_on),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // sin(r/QTR_SIZE * pi/2) in Q30, series to x^13, truncated at every step.
   // Innermost term first: divisors are (2m)(2m+1) for m = 6 down to 1.
   function automatic logic [63:0] quarter_sine_q30(int unsigned r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] d;
      x    = (64'(r) * HALF_PI) >> QTR_BITS;
      x2   = (x * x) >> FRAC;
      term = UNITY;
      for (int m = 6; m >= 1; m--) begin
         d    = ((x2 * term) >> FRAC) / (64'(2 * m) * 64'(2 * m + 1));
         term = (d >= UNITY) ? 64'd0 : UNITY - d;
      end
      x = (x * term) >> FRAC;
      return (x > UNITY) ? UNITY : x;
   endfunction

   // Advance the tone model by one word. Returns 1 when a result word is due.
   function automatic bit predict_sample(input op_type op,
                                         input logic [STEP_BITS-1:0] step,
                                         input logic [DURATION_BITS-1:0] dur,
                                         output sample_type word);
      logic [TABLE_ADDR_BITS-1:0] k;
      logic [QTR_BITS:0]          r;
      logic [63:0]                wave;
      logic [63:0]                lvl;
      word = '0;
      if (op == OP_BEEP) begin
         tone_step     = step;
         ticks_left    = dur;
         silence_count = '0;
         tone_on       = 1'b1;
         return 1'b0;
      end
      if (tone_on) begin
         if (ticks_left != 0) begin
            // level uses the phase before this tick's step
            k = phase_acc[PHASE_BITS-1 -: TABLE_ADDR_BITS];
            r = {1'b0, k[QTR_BITS-1:0]};
            if (k[QTR_BITS]) begin
               r = (QTR_BITS+1)'(QTR_SIZE) - r;   // falling quarter: mirror
            end
            wave = k[QTR_BITS+1] ? (UNITY - qsine[r]) >> 1 : (UNITY + qsine[r]) >> 1;
            lvl  = (wave * 64'(gain)) >> FRAC;
            word.level    = (lvl > 64'd65535) ? '1 : lvl[LEVEL_BITS-1:0];
            word.sounding = 1'b1;
            ticks_left    = ticks_left - COUNT_BITS'(1);
         end else begin
            // compare before counting: off once the count is past the limit
            if (silence_count > idle_ticks) begin
               tone_on = 1'b0;
            end
            if (silence_count != COUNT_TOP) begin
               silence_count = silence_count + COUNT_BITS'(1);
            end
         end
      end
      phase_acc      = phase_acc + tone_step;
      word.output_on = tone_on;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatches < 100) begin
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   // result checker: compares each accepted word with the oldest prediction
   always @(posedge clock) begin
      sample_type want;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("word with none pending", rsp_level, 0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_level !== want.level) begin
               report_mismatch("level", rsp_level, want.level);
            end
            if (rsp_sounding !== want.sounding) begin
               report_mismatch("sounding", rsp_sounding, want.sounding);
            end
            if (rsp_output_on !== want.output_on) begin
               report_mismatch("output_on", rsp_output_on, want.output_on);
            end
         end
      end
   end

   // receiver: random stall bursts, calm stretches, one long hold-off
   int rsp_burst = 0;
   int rsp_calm  = 0;
   always @(posedge clock) begin
      if (pressure_go && pressure_cycles < PRESSURE_HOLD) begin
         // sender keeps pushing; both pipe stages fill and req_stall rises
         rsp_stall <= 1'b1;
         pressure_cycles++;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_stall <= 1'b0;
         rsp_calm--;
      end else if (rsp_burst > 0) begin
         rsp_stall <= 1'b1;
         rsp_burst--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rsp_burst = $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 24) == 0) begin
            rsp_calm = $urandom_range(10, 60);
         end
      end
   end

   // Offer one word, wait for the handshake, then predict. The valid stays
   // high after acceptance; only an idle gap or drain_pipe lowers it.
   task automatic play_word(input op_type op, input logic [STEP_BITS-1:0] step,
                            input logic [DURATION_BITS-1:0] dur,
                            input bit typed = 1'b0, input sample_type typed_word = '0);
      sample_type word;
      if (!no_idle) begin
         if (sender_calm > 0) begin
            sender_calm--;
         end else if ($urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else if ($urandom_range(0, 19) == 0) begin
            sender_calm = $urandom_range(10, 60);
         end
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_phase_step     <= step;
      req_duration_ticks <= dur;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict_sample(op, step, dur, word)) begin
         expected_samples.push_back(typed ? typed_word : word);
      end
   endtask

   // all results in, then let a trailing beep leave the pipe
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_VOLUME) begin
         gain = data[VOLUME_BITS-1:0];
      end else begin
         idle_ticks = data[IDLE_BITS-1:0];
      end
   endtask

   function automatic logic [STEP_BITS-1:0] random_step();
      case ($urandom_range(0, 3))
         0:       return STEP_BITS'($urandom_range(0, 4096));
         1:       return STEP_BITS'($urandom_range(0, 15)) << (STEP_BITS - 4); // sixteenth-turn steps
         default: return STEP_BITS'($urandom);
      endcase
   endfunction

   // Mostly a beep followed by a run of up to 25 ticks that can outlast short
   // tones and small idle limits; the rest is loose noise of either operation.
   task automatic play_random(input int count);
      int sent;
      int ticks;
      logic [DURATION_BITS-1:0] dur;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 8) begin
            dur = ($urandom_range(0, 7) == 0) ? DURATION_BITS'($urandom)
                                              : DURATION_BITS'($urandom_range(0, 12));
            play_word(OP_BEEP, random_step(), dur);
            ticks = $urandom_range(0, 25);
            sent += ticks + 1;
            repeat (ticks) play_word(OP_TICK, STEP_BITS'($urandom), DURATION_BITS'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               play_word(op_type'($urandom_range(0, 1)), STEP_BITS'($urandom),
                         DURATION_BITS'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 8)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [VOLUME_BITS-1:0] vol;
      logic [IDLE_BITS-1:0]   limit;

      for (int r = 0; r <= QTR_SIZE; r++) begin
         qsine[r] = quarter_sine_q30(r);
      end
      phase_acc     = '0;
      tone_step     = '0;
      ticks_left    = '0;
      silence_count = '0;
      tone_on       = 1'b0;
      gain          = 16'd65535;
      idle_ticks    = 22'd220500;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part with reset register values
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         play_word(DIRECTED[i].op, DIRECTED[i].step, DIRECTED[i].dur, DIRECTED[i].typed,
                   '{DIRECTED[i].want_level, DIRECTED[i].want_sounding, DIRECTED[i].want_on});
      end

      // random phases, each under its own volume and idle limit
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       begin vol = 16'd0;     limit = '0;  end             // silent, lowest idle limit
            1:       begin vol = 16'd1;     limit = '1;  end             // never times out
            2:       begin vol = 16'hFFFF;  limit = 22'd2; end
            3:       begin vol = 16'h8000;  limit = IDLE_BITS'($urandom_range(0, 30)); end
            default: begin vol = VOLUME_BITS'($urandom);
                           limit = IDLE_BITS'($urandom_range(0, 60)); end
         endcase
         drain_pipe();
         // upper data bits are don't-care for volume; toggle them anyway
         write_reg(CSR_VOLUME, {6'($urandom), vol});
         write_reg(CSR_IDLE_LIMIT, limit);
         csr_write <= 1'b0;
         if (ph == 2) begin
            pressure_go <= 1'b1;
            sender_calm = 80;
         end
         if (ph == PHASE_COUNT - 1) begin
            no_idle <= 1'b1;
         end
         play_random(PHASE_WORDS);
      end

      drain_pipe();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tsg_pkg.sv
hdl/tsg_ctrl.sv
hdl/tsg_wave.sv
hdl/timed_sine_tone_generator.sv
hdl/tsg_checker.sv
tb/sv/tb_timed_sine_tone_generator.sv
